// File: src/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg: shared types and constants of the triangle tangent basis unit
// Vertex and result items, the triangle job handed from front to back, and
// the default fixed-point formats.
// ----------------------------------------------------------------------------
`default_nettype none

package ttb_pkg;

  // Default fixed-point formats
  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int OUT_FRAC_BITS_DEF   = 14;

  // Reset value of the determinant threshold
  localparam logic [15:0] DET_EPS_RESET = 16'd7;

  // Internal widths
  localparam int EDGE_W = 33;  // difference of two 32-bit coordinates
  localparam int OPND_W = 34;  // multiplier operand
  localparam int PROD_W = 67;  // product and difference of products
  localparam int MAG_W  = 66;  // magnitude of a difference of products
  localparam int NRM_W  = 30;  // normalized component magnitude
  localparam int SQR_W  = 64;  // sum of squares and root iteration
  localparam int ROOT_W = 31;  // integer square root

  // Output saturation limits
  localparam logic [15:0] SAT_POS = 16'h7FFF;
  localparam logic [15:0] SAT_NEG = 16'h8000;

  // Input vertex item
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
  } vtx_t;

  // Result item
  typedef struct packed {
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] binormal_x;
    logic signed [15:0] binormal_y;
    logic signed [15:0] binormal_z;
    logic               degenerate_uv;
    logic               zero_tangent;
    logic               zero_binormal;
  } res_t;

  typedef logic signed [EDGE_W-1:0] edge_t;

  // One triangle: edges and UV deltas
  typedef struct packed {
    edge_t e1_x;
    edge_t e1_y;
    edge_t e1_z;
    edge_t e2_x;
    edge_t e2_y;
    edge_t e2_z;
    edge_t d1_u;
    edge_t d1_v;
    edge_t d2_u;
    edge_t d2_v;
  } job_t;

  // Sign-extended difference a - b of two 32-bit values
  function automatic edge_t sub_ext(logic [31:0] a, logic [31:0] b);
    logic [EDGE_W-1:0] d;
    d = {a[31], a} - {b[31], b};
    return edge_t'(d);
  endfunction

endpackage

`default_nettype wire

// File: src/ttb_front.sv
// ----------------------------------------------------------------------------
// ttb_front: vertex intake
// Keeps the first two corners of a triangle and, on the third, pushes the
// edge vectors and UV deltas into the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_push,
  input  wire ttb_pkg::vtx_t   in_data,
  output logic                 in_full,
  input  wire                  q_full,
  output logic                 q_push,
  output ttb_pkg::job_t        q_data
);

  localparam logic [1:0] CORNER_FIRST  = 2'd0;
  localparam logic [1:0] CORNER_SECOND = 2'd1;
  localparam logic [1:0] CORNER_THIRD  = 2'd2;

  logic [1:0]    corner_r, corner_nxt;
  ttb_pkg::vtx_t p1_r, p2_r;
  logic          accept;

  // Stall only the closing corner when the queue has no room
  assign in_full = (corner_r == CORNER_THIRD) && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = accept && (corner_r == CORNER_THIRD);

  // Form edges and UV deltas from the stored corners
  always_comb begin
    q_data.e1_x = ttb_pkg::sub_ext(p2_r.pos_x, p1_r.pos_x);
    q_data.e1_y = ttb_pkg::sub_ext(p2_r.pos_y, p1_r.pos_y);
    q_data.e1_z = ttb_pkg::sub_ext(p2_r.pos_z, p1_r.pos_z);
    q_data.e2_x = ttb_pkg::sub_ext(in_data.pos_x, p1_r.pos_x);
    q_data.e2_y = ttb_pkg::sub_ext(in_data.pos_y, p1_r.pos_y);
    q_data.e2_z = ttb_pkg::sub_ext(in_data.pos_z, p1_r.pos_z);
    q_data.d1_u = ttb_pkg::sub_ext(p2_r.tex_u, p1_r.tex_u);
    q_data.d1_v = ttb_pkg::sub_ext(p2_r.tex_v, p1_r.tex_v);
    q_data.d2_u = ttb_pkg::sub_ext(in_data.tex_u, p1_r.tex_u);
    q_data.d2_v = ttb_pkg::sub_ext(in_data.tex_v, p1_r.tex_v);
  end

  // Advance the corner count
  always_comb begin
    corner_nxt = corner_r;
    if (accept) begin
      case (corner_r)
        CORNER_FIRST:  corner_nxt = CORNER_SECOND;
        CORNER_SECOND: corner_nxt = CORNER_THIRD;
        default:       corner_nxt = CORNER_FIRST;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_r <= CORNER_FIRST;
    end else begin
      corner_r <= corner_nxt;
    end
  end

  // Hold the first two corners
  always_ff @(posedge clk) begin
    if (accept && corner_r == CORNER_FIRST) begin
      p1_r <= in_data;
    end
    if (accept && corner_r == CORNER_SECOND) begin
      p2_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// File: src/ttb_fifo.sv
// ----------------------------------------------------------------------------
// ttb_fifo: two-entry job queue
// Decouples vertex intake from the arithmetic sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_fifo (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  push,
  input  wire ttb_pkg::job_t   push_data,
  output logic                 full,
  input  wire                  pop,
  output ttb_pkg::job_t        pop_data,
  output logic                 empty
);

  ttb_pkg::job_t mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;
  logic          do_push, do_pop;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: src/ttb_back.sv
// ----------------------------------------------------------------------------
// ttb_back: tangent and binormal sequencer
// Shared 34x34 multiplier for the cross terms and squares, bit-serial square
// root and divider, and the output register of the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ttb_back #(
  parameter int COORD_FRAC_BITS = ttb_pkg::COORD_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS   = ttb_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire  [15:0]          det_eps,
  input  wire                  q_empty,
  input  wire ttb_pkg::job_t   q_data,
  output logic                 q_pop,
  output logic                 out_empty,
  input  wire                  out_pop,
  output ttb_pkg::res_t        out_data
);

  localparam int NUM_W  = ttb_pkg::NRM_W + OUT_FRAC_BITS + 1;
  localparam int DCNT_W = $clog2(NUM_W + 1);
  localparam int EPS_W  = 16 + COORD_FRAC_BITS;
  localparam int PW     = ttb_pkg::PROD_W;
  localparam int MW     = ttb_pkg::MAG_W;
  localparam int AW     = ttb_pkg::NRM_W;
  localparam int SW     = ttb_pkg::SQR_W;
  localparam int RW     = ttb_pkg::ROOT_W;
  localparam int OW     = ttb_pkg::OPND_W;

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_PROD    = 13'b0000000000010,
    S_PDRAIN  = 13'b0000000000100,
    S_SIGN    = 13'b0000000001000,
    S_MAG     = 13'b0000000010000,
    S_NORM    = 13'b0000000100000,
    S_SQ      = 13'b0000001000000,
    S_SQDRAIN = 13'b0000010000000,
    S_SQRT    = 13'b0000100000000,
    S_DLOAD   = 13'b0001000000000,
    S_DIV     = 13'b0010000000000,
    S_DSTORE  = 13'b0100000000000,
    S_OUT     = 13'b1000000000000
  } state_t;

  state_t                state_r, state_nxt;
  ttb_pkg::job_t         job_r, job_nxt;
  logic [3:0]            cnt_r, cnt_nxt;
  logic                  pv_r, pv_nxt;
  logic                  psq_r, psq_nxt;
  logic [3:0]            pidx_r, pidx_nxt;
  logic signed [PW-1:0]  prod_r, prod_nxt;
  logic signed [PW-1:0]  hold_r, hold_nxt;
  logic signed [PW-1:0]  vec_r [7];
  logic signed [PW-1:0]  vec_nxt [7];
  logic                  sel_r, sel_nxt;
  logic [MW-1:0]         m_r [3];
  logic [MW-1:0]         m_nxt [3];
  logic [2:0]            neg_r, neg_nxt;
  logic [SW-1:0]         rem_r, rem_nxt;
  logic [SW-1:0]         root_r, root_nxt;
  logic [SW-1:0]         bit_r, bit_nxt;
  logic [RW-1:0]         n_r, n_nxt;
  logic [NUM_W-1:0]      num_r, num_nxt;
  logic [NUM_W-1:0]      quo_r, quo_nxt;
  logic [RW-1:0]         drem_r, drem_nxt;
  logic [DCNT_W-1:0]     dcnt_r, dcnt_nxt;
  ttb_pkg::res_t         res_r, res_nxt;
  ttb_pkg::res_t         obuf_r, obuf_nxt;
  logic                  ovalid_r, ovalid_nxt;

  logic signed [OW-1:0]  op_a, op_b;
  logic signed [2*OW-1:0] mul_full;
  logic signed [PW-1:0]  det_mag;
  logic [PW-1:0]         eps_ext;
  logic                  degen, flip;
  logic [MW-1:0]         orv;
  logic [AW-1:0]         a_sel;
  logic [SW-1:0]         sq_try;
  logic [RW:0]           rem_w;
  logic [RW:0]           rem_sub;
  logic [NUM_W-1:0]      num_init;
  logic [15:0]           comp;
  logic signed [PW-1:0]  vsel [3];

  assign out_empty = !ovalid_r;
  assign out_data  = obuf_r;
  assign q_pop     = (state_r == S_IDLE) && !q_empty;

  // Pick the normalized component under work
  always_comb begin
    case (cnt_r[1:0])
      2'd0:    a_sel = m_r[0][AW-1:0];
      2'd1:    a_sel = m_r[1][AW-1:0];
      default: a_sel = m_r[2][AW-1:0];
    endcase
  end

  // Select multiplier operands: cross terms, then squares
  always_comb begin
    op_a = '0;
    op_b = '0;
    if (state_r == S_SQ) begin
      op_a = OW'(a_sel);
      op_b = OW'(a_sel);
    end else begin
      case (cnt_r)
        4'd0:    begin op_a = OW'(job_r.d1_u); op_b = OW'(job_r.d2_v); end
        4'd1:    begin op_a = OW'(job_r.d1_v); op_b = OW'(job_r.d2_u); end
        4'd2:    begin op_a = OW'(job_r.e1_x); op_b = OW'(job_r.d2_v); end
        4'd3:    begin op_a = OW'(job_r.e2_x); op_b = OW'(job_r.d1_v); end
        4'd4:    begin op_a = OW'(job_r.e1_y); op_b = OW'(job_r.d2_v); end
        4'd5:    begin op_a = OW'(job_r.e2_y); op_b = OW'(job_r.d1_v); end
        4'd6:    begin op_a = OW'(job_r.e1_z); op_b = OW'(job_r.d2_v); end
        4'd7:    begin op_a = OW'(job_r.e2_z); op_b = OW'(job_r.d1_v); end
        4'd8:    begin op_a = OW'(job_r.e2_x); op_b = OW'(job_r.d1_u); end
        4'd9:    begin op_a = OW'(job_r.e1_x); op_b = OW'(job_r.d2_u); end
        4'd10:   begin op_a = OW'(job_r.e2_y); op_b = OW'(job_r.d1_u); end
        4'd11:   begin op_a = OW'(job_r.e1_y); op_b = OW'(job_r.d2_u); end
        4'd12:   begin op_a = OW'(job_r.e2_z); op_b = OW'(job_r.d1_u); end
        4'd13:   begin op_a = OW'(job_r.e1_z); op_b = OW'(job_r.d2_u); end
        default: begin op_a = '0; op_b = '0; end
      endcase
    end
  end

  assign mul_full = op_a * op_b;

  // Degenerate test on the determinant
  assign det_mag = vec_r[0][PW-1] ? -vec_r[0] : vec_r[0];
  assign eps_ext = PW'({det_eps, {COORD_FRAC_BITS{1'b0}}});
  assign degen   = (det_mag[PW-1:EPS_W] == '0 && det_mag[EPS_W-1:0] < eps_ext[EPS_W-1:0])
                   || (vec_r[0] == '0);
  assign flip    = !degen && vec_r[0][PW-1];

  // Vector under normalization: tangent first, then binormal
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vsel[i] = sel_r ? vec_r[4+i] : vec_r[1+i];
    end
  end

  assign orv      = m_r[0] | m_r[1] | m_r[2];
  assign sq_try   = root_r + bit_r;
  assign rem_w    = {drem_r, num_r[NUM_W-1]};
  assign rem_sub  = rem_w - {1'b0, n_r};
  assign num_init = NUM_W'({a_sel, {OUT_FRAC_BITS{1'b0}}}) + NUM_W'(n_r >> 1);

  // Saturate the quotient with the component sign
  always_comb begin
    if (neg_r[cnt_r[1:0]]) begin
      if (quo_r > NUM_W'(ttb_pkg::SAT_NEG)) comp = ttb_pkg::SAT_NEG;
      else comp = 16'(-quo_r[15:0]);
    end else begin
      if (quo_r > NUM_W'(ttb_pkg::SAT_POS)) comp = ttb_pkg::SAT_POS;
      else comp = quo_r[15:0];
    end
  end

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    cnt_nxt    = cnt_r;
    pv_nxt     = 1'b0;
    psq_nxt    = psq_r;
    pidx_nxt   = pidx_r;
    prod_nxt   = PW'(mul_full);
    hold_nxt   = hold_r;
    sel_nxt    = sel_r;
    neg_nxt    = neg_r;
    rem_nxt    = rem_r;
    root_nxt   = root_r;
    bit_nxt    = bit_r;
    n_nxt      = n_r;
    num_nxt    = num_r;
    quo_nxt    = quo_r;
    drem_nxt   = drem_r;
    dcnt_nxt   = dcnt_r;
    res_nxt    = res_r;
    obuf_nxt   = obuf_r;
    ovalid_nxt = ovalid_r && !out_pop;
    for (int i = 0; i < 7; i++) vec_nxt[i] = vec_r[i];
    for (int i = 0; i < 3; i++) m_nxt[i] = m_r[i];

    // Retire the registered product
    if (pv_r) begin
      if (psq_r) begin
        rem_nxt = rem_r + SW'(prod_r);
      end else if (!pidx_r[0]) begin
        hold_nxt = prod_r;
      end else begin
        for (int i = 0; i < 7; i++) begin
          if (pidx_r[3:1] == 3'(i)) vec_nxt[i] = hold_r - prod_r;
        end
      end
    end

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          job_nxt   = q_data;
          cnt_nxt   = 4'd0;
          state_nxt = S_PROD;
        end
      end
      S_PROD: begin
        pv_nxt   = 1'b1;
        psq_nxt  = 1'b0;
        pidx_nxt = cnt_r;
        cnt_nxt  = cnt_r + 4'd1;
        if (cnt_r == 4'd13) state_nxt = S_PDRAIN;
      end
      S_PDRAIN: begin
        state_nxt = S_SIGN;
      end
      S_SIGN: begin
        res_nxt.degenerate_uv = degen;
        if (flip) begin
          for (int i = 1; i < 7; i++) vec_nxt[i] = -vec_r[i];
        end
        sel_nxt   = 1'b0;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        for (int i = 0; i < 3; i++) begin
          neg_nxt[i] = vsel[i][PW-1];
          m_nxt[i]   = vsel[i][PW-1] ? MW'(-vsel[i]) : MW'(vsel[i]);
        end
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (orv == '0) begin
          if (!sel_r) begin
            res_nxt.zero_tangent = 1'b1;
            res_nxt.tangent_x    = '0;
            res_nxt.tangent_y    = '0;
            res_nxt.tangent_z    = '0;
            sel_nxt              = 1'b1;
            state_nxt            = S_MAG;
          end else begin
            res_nxt.zero_binormal = 1'b1;
            res_nxt.binormal_x    = '0;
            res_nxt.binormal_y    = '0;
            res_nxt.binormal_z    = '0;
            state_nxt             = S_OUT;
          end
        end else if (orv[MW-1:AW] != '0) begin
          // Truncating one-bit right shift, repeated
          for (int i = 0; i < 3; i++) m_nxt[i] = m_r[i] >> 1;
        end else if (!orv[AW-1]) begin
          for (int i = 0; i < 3; i++) m_nxt[i] = m_r[i] << 1;
        end else begin
          if (!sel_r) res_nxt.zero_tangent = 1'b0;
          else res_nxt.zero_binormal = 1'b0;
          cnt_nxt   = 4'd0;
          rem_nxt   = '0;
          root_nxt  = '0;
          bit_nxt   = SW'(1) << (SW - 2);
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        pv_nxt  = 1'b1;
        psq_nxt = 1'b1;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd2) state_nxt = S_SQDRAIN;
      end
      S_SQDRAIN: begin
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (bit_r != '0) begin
          if (rem_r >= sq_try) begin
            rem_nxt  = rem_r - sq_try;
            root_nxt = (root_r >> 1) + bit_r;
          end else begin
            root_nxt = root_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end else begin
          n_nxt     = root_r[RW-1:0];
          cnt_nxt   = 4'd0;
          state_nxt = S_DLOAD;
        end
      end
      S_DLOAD: begin
        num_nxt   = num_init;
        quo_nxt   = '0;
        drem_nxt  = '0;
        dcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // One restoring division step
        if (!rem_sub[RW]) begin
          drem_nxt = rem_sub[RW-1:0];
          quo_nxt  = {quo_r[NUM_W-2:0], 1'b1};
        end else begin
          drem_nxt = rem_w[RW-1:0];
          quo_nxt  = {quo_r[NUM_W-2:0], 1'b0};
        end
        num_nxt  = num_r << 1;
        dcnt_nxt = dcnt_r + DCNT_W'(1);
        if (dcnt_r == DCNT_W'(NUM_W - 1)) state_nxt = S_DSTORE;
      end
      S_DSTORE: begin
        case ({sel_r, cnt_r[1:0]})
          3'b000:  res_nxt.tangent_x  = comp;
          3'b001:  res_nxt.tangent_y  = comp;
          3'b010:  res_nxt.tangent_z  = comp;
          3'b100:  res_nxt.binormal_x = comp;
          3'b101:  res_nxt.binormal_y = comp;
          default: res_nxt.binormal_z = comp;
        endcase
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r != 4'd2) begin
          state_nxt = S_DLOAD;
        end else if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = S_MAG;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hand over once the output register is free
        if (!ovalid_r || out_pop) begin
          obuf_nxt   = res_r;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      pv_r     <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pv_r     <= pv_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    cnt_r  <= cnt_nxt;
    psq_r  <= psq_nxt;
    pidx_r <= pidx_nxt;
    prod_r <= prod_nxt;
    hold_r <= hold_nxt;
    sel_r  <= sel_nxt;
    neg_r  <= neg_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    n_r    <= n_nxt;
    num_r  <= num_nxt;
    quo_r  <= quo_nxt;
    drem_r <= drem_nxt;
    dcnt_r <= dcnt_nxt;
    res_r  <= res_nxt;
    obuf_r <= obuf_nxt;
    for (int i = 0; i < 7; i++) vec_r[i] <= vec_nxt[i];
    for (int i = 0; i < 3; i++) m_r[i] <= m_nxt[i];
  end

endmodule

`default_nettype wire

// File: src/triangle_tangent_basis_unit.sv
// The back sequencer works on one triangle at a time, held by the bit-serial
// divider (three divisions per vector) and square root, and takes no new job
// until its result is in the output register; the queue holds two more.
// Reset: synchronous active-low rst_n empties the job queue and result
// register, restarts at the first corner and loads det_eps_r with 7.
// ----------------------------------------------------------------------------
// triangle_tangent_basis_unit: per-triangle tangent and binormal
// Front stores corners and forms edges, a two-entry queue buffers triangles,
// back computes and normalizes the tangent frame.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_tangent_basis_unit #(
  parameter int COORD_FRAC_BITS = ttb_pkg::COORD_FRAC_BITS_DEF,
  parameter int OUT_FRAC_BITS   = ttb_pkg::OUT_FRAC_BITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_push,
  input  wire ttb_pkg::vtx_t   in_data,
  output logic                 in_full,
  output logic                 out_empty,
  input  wire                  out_pop,
  output ttb_pkg::res_t        out_data,
  input  wire                  cfg_we,
  input  wire  [15:0]          cfg_wdata
);

  logic [15:0]   det_eps_r, det_eps_nxt;
  logic          q_push, q_full, q_pop, q_empty;
  ttb_pkg::job_t q_wdata, q_rdata;

  // Hold the determinant threshold
  assign det_eps_nxt = cfg_we ? cfg_wdata : det_eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      det_eps_r <= ttb_pkg::DET_EPS_RESET;
    end else begin
      det_eps_r <= det_eps_nxt;
    end
  end

  ttb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  ttb_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  ttb_back #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .OUT_FRAC_BITS   (OUT_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .det_eps   (det_eps_r),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
